@@ rtl/histogram_median_edge_thresholds_macros.svh @@
// Assertion macros shared by the checker of the histogram median block.
// No dependencies; include by bare file name.
`ifndef HISTOGRAM_MEDIAN_EDGE_THRESHOLDS_MACROS_SVH
`define HISTOGRAM_MEDIAN_EDGE_THRESHOLDS_MACROS_SVH

// Same-cycle implication, disabled while reset is low.
`define HMET_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is low.
`define HMET_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/hmet_pkg.sv @@
// Shared constants and types of the histogram median threshold block.
// No dependencies; imported by hmet_thresh, the top level and the testbench.
`default_nettype none

package hmet_pkg;

    localparam int LVL_W       = 8;
    localparam int LEVELS      = 1 << LVL_W;
    localparam int MAX_PIXELS  = 262144;
    localparam int CNT_W       = $clog2(MAX_PIXELS + 1);
    localparam int SIGMA_W     = 9;
    localparam int SIGMA_RESET = 84;
    localparam int Q8_ONE      = 256;

    typedef logic [LVL_W-1:0]   t_level;
    typedef logic [CNT_W-1:0]   t_count;
    typedef logic [SIGMA_W-1:0] t_sigma;

    typedef struct packed {
        t_level lower;
        t_level upper;
    } t_thresh;

    typedef enum logic [5:0] {
        ST_CLEAR = 6'b000001,
        ST_IDLE  = 6'b000010,
        ST_DRAIN = 6'b000100,
        ST_SCAN  = 6'b001000,
        ST_TAIL  = 6'b010000,
        ST_CALC  = 6'b100000
    } t_state;

endpackage

`default_nettype wire

@@ rtl/hmet_thresh.sv @@
// Edge threshold arithmetic: scales the median by (1 -/+ sigma) in Q8.
// Depends on hmet_pkg.
`default_nettype none

module hmet_thresh
    import hmet_pkg::*;
(
    input  wire t_level  i_median,
    input  wire t_sigma  i_sigma,
    output t_thresh      o_thresh
);

    localparam int LO_F_W = SIGMA_W;
    localparam int HI_F_W = SIGMA_W + 1;
    localparam int LO_P_W = LO_F_W + LVL_W;
    localparam int HI_P_W = HI_F_W + LVL_W;

    logic [LO_F_W-1:0] lo_factor;
    logic [HI_F_W-1:0] hi_factor;
    logic [LO_P_W-1:0] lo_prod;
    logic [HI_P_W-1:0] hi_prod;
    logic [HI_P_W-9:0] hi_quot;

    always_comb begin
        // spread of a whole unit or more drives the lower bound to zero
        lo_factor = i_sigma[SIGMA_W-1] ? '0 : (LO_F_W'(Q8_ONE) - i_sigma);
        hi_factor = HI_F_W'(Q8_ONE) + HI_F_W'(i_sigma);
        lo_prod   = LO_P_W'(lo_factor) * LO_P_W'(i_median);
        hi_prod   = HI_P_W'(hi_factor) * HI_P_W'(i_median);
        hi_quot   = hi_prod[HI_P_W-1:8];
        o_thresh.lower = lo_prod[LVL_W+7:8];
        if (hi_quot > (HI_P_W-8)'(LEVELS - 1)) begin
            o_thresh.upper = t_level'(LEVELS - 1);
        end else begin
            o_thresh.upper = hi_quot[LVL_W-1:0];
        end
    end

endmodule

`default_nettype wire

@@ rtl/histogram_median_edge_thresholds.sv @@
// Histogram median and edge threshold generator
//
// Pixels enter on the s_axis channel, one 8-bit grey level per request, and
// are counted into a 256-bin histogram held in a synchronous RAM. Each pixel
// is a read-modify-write; a one-entry bypass covers back-to-back pixels of
// the same level, so the input takes one pixel per cycle until the frame end.
// The request carrying tlast closes the frame: the input then drops tready,
// the RAM is scanned one bin per cycle (each bin is zeroed as it is read) and
// the median and thresholds are computed. A result appears on m_axis after the
// drain, scan, tail and compute states, and the input reopens in the same cycle.
// The frame rate is therefore set by the single RAM port: pixels at one per cycle
// plus the drain, a scan of every bin, the tail and the compute of each frame.
// The result sits in an output register; if m_axis stalls, new pixels are
// still taken and only the next frame end waits for the register to free.
// After reset the RAM is cleared in a pass over every bin with tready low;
// sigma resets to 84 and may be written through i_cfg_wr_en at any idle time.
// Pixels beyond the counter limit are dropped and flagged in tuser.
// Depends on hmet_pkg and hmet_thresh.
`default_nettype none

module histogram_median_edge_thresholds
    import hmet_pkg::*;
(
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_cfg_wr_en,
    input  wire [8:0]   i_cfg_wr_data,   // sigma_q8
    input  wire         s_axis_tvalid,
    output logic        s_axis_tready,
    input  wire [7:0]   s_axis_tdata,    // [7:0] pixel
    input  wire         s_axis_tlast,    // last_pixel
    output logic        m_axis_tvalid,
    input  wire         m_axis_tready,
    output logic [23:0] m_axis_tdata,    // [7:0] median, [15:8] lower, [23:16] upper
    output logic        m_axis_tuser     // [0] count_overflow
);

    t_state  r_state, n_state;
    t_level  r_scan_addr;
    t_sigma  r_sigma;
    t_count  r_total;
    logic    r_ovf;

    t_count  r_hist [LEVELS];
    t_count  r_rd_data;

    logic    r_s1_valid;
    t_level  r_s1_addr;
    logic    r_wr_valid;
    t_level  r_wr_addr;
    t_count  r_wr_data;

    logic    r_sd_valid;
    t_level  r_sd_addr;
    t_count  r_run;
    logic    r_found;
    t_level  r_median;

    logic    r_m_valid;
    logic [23:0] r_m_data;
    logic    r_m_user;

    logic    in_acc;
    logic    cnt_ok;
    logic    wr_en;
    t_level  wr_addr;
    t_count  wr_data;
    t_level  rd_addr;
    t_count  cur_bin;
    t_count  run_sum;
    t_count  half;
    logic    out_free;
    t_level  median_sel;
    t_thresh thresh;

    assign s_axis_tready = (r_state == ST_IDLE);
    assign in_acc        = s_axis_tvalid && s_axis_tready;
    assign cnt_ok        = (r_total != t_count'(MAX_PIXELS));
    assign half          = r_total >> 1;
    assign run_sum       = r_run + r_rd_data;
    assign out_free      = !r_m_valid || m_axis_tready;
    assign median_sel    = r_found ? r_median : '0;

    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = r_m_data;
    assign m_axis_tuser  = r_m_user;

    // bypass the bin written last cycle: the RAM returned its old value
    always_comb begin
        if (r_wr_valid && (r_wr_addr == r_s1_addr)) begin
            cur_bin = r_wr_data;
        end else begin
            cur_bin = r_rd_data;
        end
        if ((r_state == ST_CLEAR) || (r_state == ST_SCAN)) begin
            wr_en   = 1'b1;
            wr_addr = r_scan_addr;
            wr_data = '0;
        end else begin
            wr_en   = r_s1_valid;
            wr_addr = r_s1_addr;
            wr_data = cur_bin + t_count'(1);
        end
        rd_addr = (r_state == ST_SCAN) ? r_scan_addr : s_axis_tdata;
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_CLEAR: if (r_scan_addr == t_level'(LEVELS - 1)) n_state = ST_IDLE;
            ST_IDLE:  if (in_acc && s_axis_tlast) n_state = ST_DRAIN;
            ST_DRAIN: n_state = ST_SCAN;
            ST_SCAN:  if (r_scan_addr == t_level'(LEVELS - 1)) n_state = ST_TAIL;
            ST_TAIL:  n_state = ST_CALC;
            ST_CALC:  if (out_free) n_state = ST_IDLE;
            default:  n_state = ST_CLEAR;
        endcase
    end

    hmet_thresh u_thresh (
        .i_median (median_sel),
        .i_sigma  (r_sigma),
        .o_thresh (thresh)
    );

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_hist[wr_addr] <= wr_data;
        end
        r_rd_data <= r_hist[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_scan_addr <= '0;
            r_sigma     <= t_sigma'(SIGMA_RESET);
            r_total     <= '0;
            r_ovf       <= 1'b0;
            r_s1_valid  <= 1'b0;
            r_wr_valid  <= 1'b0;
            r_sd_valid  <= 1'b0;
            r_found     <= 1'b0;
            r_run       <= '0;
            r_m_valid   <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_wr_en) begin
                r_sigma <= i_cfg_wr_data;
            end

            if ((r_state == ST_CLEAR) || (r_state == ST_SCAN)) begin
                r_scan_addr <= r_scan_addr + t_level'(1);
            end

            // count the pixel, or drop it once the counter is full
            r_s1_valid <= in_acc && cnt_ok;
            if (in_acc) begin
                if (cnt_ok) begin
                    r_total <= r_total + t_count'(1);
                end else begin
                    r_ovf <= 1'b1;
                end
            end

            r_wr_valid <= wr_en;

            r_sd_valid <= (r_state == ST_SCAN);
            if (r_state == ST_DRAIN) begin
                r_run   <= '0;
                r_found <= 1'b0;
            end else if (r_sd_valid) begin
                r_run <= run_sum;
                if (!r_found && (run_sum > half)) begin
                    r_found <= 1'b1;
                end
            end

            if ((r_state == ST_CALC) && out_free) begin
                r_m_valid <= 1'b1;
                r_total   <= '0;
                r_ovf     <= 1'b0;
            end else if (m_axis_tready) begin
                r_m_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_s1_addr <= s_axis_tdata;
        r_wr_addr <= wr_addr;
        r_wr_data <= wr_data;
        r_sd_addr <= r_scan_addr;
        if (r_sd_valid && !r_found && (run_sum > half)) begin
            r_median <= r_sd_addr;
        end
        if ((r_state == ST_CALC) && out_free) begin
            r_m_data <= {thresh.upper, thresh.lower, median_sel};
            r_m_user <= r_ovf;
        end
    end

endmodule

`default_nettype wire

@@ rtl/hmet_checker.sv @@
// Port-level checker for the histogram median block, bound to the top level.
// Depends on histogram_median_edge_thresholds_macros.svh.
`default_nettype none
`include "histogram_median_edge_thresholds_macros.svh"

module hmet_checker (
    input wire        i_clk,
    input wire        i_rst_n,
    input wire        i_cfg_wr_en,
    input wire [8:0]  i_cfg_wr_data,
    input wire        s_axis_tvalid,
    input wire        s_axis_tready,
    input wire [7:0]  s_axis_tdata,
    input wire        s_axis_tlast,
    input wire        m_axis_tvalid,
    input wire        m_axis_tready,
    input wire [23:0] m_axis_tdata,
    input wire        m_axis_tuser
);

    // hold a stalled result
    `HMET_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid, "result request dropped while stalled")
    `HMET_ASSERT_NEXT(a_out_stable, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tready, $stable(m_axis_tdata) && $stable(m_axis_tuser), "result changed while stalled")
    // thresholds bracket the median
    `HMET_ASSERT_NOW(a_upper_ge, i_clk, i_rst_n, m_axis_tvalid, m_axis_tdata[23:16] >= m_axis_tdata[7:0], "upper threshold below median")
    `HMET_ASSERT_NOW(a_lower_le, i_clk, i_rst_n, m_axis_tvalid, m_axis_tdata[15:8] <= m_axis_tdata[7:0], "lower threshold above median")
    // close the input at the frame end
    `HMET_ASSERT_NEXT(a_frame_close, i_clk, i_rst_n, s_axis_tvalid && s_axis_tready && s_axis_tlast, !s_axis_tready, "pixel taken right after frame end")

endmodule

bind histogram_median_edge_thresholds hmet_checker u_hmet_checker (.*);

`default_nettype wire

@@ tb/hmet_frame_stats_checker.sv @@
// Checker for the histogram median block: watches the pixel, result and sigma ports,
// predicts each frame's median, thresholds and overflow flag, and compares them.
// Depends on hmet_pkg.
module hmet_frame_stats_checker
    import hmet_pkg::*;
(
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_cfg_wr_en,
    input  wire [8:0]   i_cfg_wr_data,
    input  wire         i_pix_valid,
    input  wire         i_pix_ready,
    input  wire [7:0]   i_pix_data,
    input  wire         i_pix_last,
    input  wire         i_stats_valid,
    input  wire         i_stats_ready,
    input  wire [23:0]  i_stats_data,
    input  wire         i_stats_user,
    output int          o_fail_count,
    output int          o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        t_level median;
        t_level lower;
        t_level upper;
        logic   overflow;
    } t_frame_stats;

    t_count       level_counts [LEVELS];
    t_count       frame_pixels;
    logic         frame_clipped;
    t_sigma       spread_q8;
    t_frame_stats expected_stats [$];

    function automatic void clear_frame();
        foreach (level_counts[lv]) level_counts[lv] = '0;
        frame_pixels  = '0;
        frame_clipped = 1'b0;
    endfunction

    // Median from the running bin sum, then both thresholds from the spread.
    function automatic t_frame_stats close_frame();
        t_frame_stats st;
        int half;
        int run;
        int med;
        int lo;
        int hi;
        logic found;
        half  = int'(frame_pixels) / 2;
        run   = 0;
        med   = 0;
        found = 1'b0;
        for (int lv = 0; lv < LEVELS; lv++) begin
            run += int'(level_counts[lv]);
            if (!found && run > half) begin
                med   = lv;
                found = 1'b1;
            end
        end
        lo = (int'(spread_q8) >= Q8_ONE) ? 0 : ((Q8_ONE - int'(spread_q8)) * med) >> 8;
        hi = ((Q8_ONE + int'(spread_q8)) * med) >> 8;
        if (hi > 255) hi = 255;
        st.median   = t_level'(med);
        st.lower    = t_level'(lo);
        st.upper    = t_level'(hi);
        st.overflow = frame_clipped;
        clear_frame();
        return st;
    endfunction

    function automatic void report_field(input string name, input int want, input int got);
        if (want != got) begin
            $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            o_fail_count++;
        end
    endfunction

    function automatic void check_stats(input t_frame_stats got);
        t_frame_stats want;
        if (expected_stats.size() == 0) begin
            $display({"%0t ns: unexpected result, expected none, ",
                      "actual median %0d lower %0d upper %0d overflow %0d"},
                     $time, got.median, got.lower, got.upper, got.overflow);
            o_fail_count++;
            return;
        end
        want = expected_stats.pop_front();
        report_field("median", want.median, got.median);
        report_field("lower", want.lower, got.lower);
        report_field("upper", want.upper, got.upper);
        report_field("overflow", want.overflow, got.overflow);
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            clear_frame();
            spread_q8 = t_sigma'(SIGMA_RESET);
            expected_stats.delete();
        end else begin
            if (i_cfg_wr_en) spread_q8 = i_cfg_wr_data;
            if (i_stats_valid && i_stats_ready)
                check_stats({i_stats_data[7:0], i_stats_data[15:8], i_stats_data[23:16],
                             i_stats_user});
            if (i_pix_valid && i_pix_ready) begin
                // drop the pixel once the counter is full, but flag the frame as clipped
                if (int'(frame_pixels) < MAX_PIXELS) begin
                    level_counts[i_pix_data] = level_counts[i_pix_data] + 1'b1;
                    frame_pixels = frame_pixels + 1'b1;
                end else begin
                    frame_clipped = 1'b1;
                end
                if (i_pix_last) expected_stats.insert(expected_stats.size(), close_frame());
            end
        end
        o_pending <= expected_stats.size();
    end

endmodule

@@ tb/histogram_median_edge_thresholds_test.sv @@
// Top of the histogram median testbench: clock, reset, pixel frames, sigma writes
// and receiver stalls; hmet_frame_stats_checker does all prediction and comparison.
// Depends on hmet_pkg, hmet_frame_stats_checker and histogram_median_edge_thresholds.
module histogram_median_edge_thresholds_test;
    import hmet_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned LIMIT_CYCLES = 2_000_000;
    localparam int unsigned HOLD_CYCLES  = 800;
    localparam int unsigned PHASE_ITEMS  = 350;
    localparam t_sigma      SPREAD_MAX   = '1;

    typedef enum int {
        SHAPE_FLAT,
        SHAPE_CLUSTER,
        SHAPE_BRIGHT,
        SHAPE_EXTREME,
        SHAPE_CONSTANT
    } t_pixel_shape;

    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        cfg_we    = 1'b0;
    logic [8:0]  cfg_data  = '0;
    logic        pix_valid = 1'b0;
    logic        pix_ready;
    logic [7:0]  pix_data  = '0;
    logic        pix_last  = 1'b0;
    logic        stats_valid;
    logic        stats_ready = 1'b0;
    logic [23:0] stats_data;
    logic        stats_user;

    int          fail_count;
    int          pending;
    int unsigned send_idle_pct  = 0;
    int unsigned recv_stall_pct = 0;
    int unsigned hold_asks      = 0;
    int unsigned hold_taken     = 0;
    int unsigned hold_left      = 0;
    int unsigned cycle_count    = 0;

    histogram_median_edge_thresholds u_dut (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_cfg_wr_en    (cfg_we),
        .i_cfg_wr_data  (cfg_data),
        .s_axis_tvalid  (pix_valid),
        .s_axis_tready  (pix_ready),
        .s_axis_tdata   (pix_data),
        .s_axis_tlast   (pix_last),
        .m_axis_tvalid  (stats_valid),
        .m_axis_tready  (stats_ready),
        .m_axis_tdata   (stats_data),
        .m_axis_tuser   (stats_user)
    );

    hmet_frame_stats_checker u_check (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_cfg_wr_en    (cfg_we),
        .i_cfg_wr_data  (cfg_data),
        .i_pix_valid    (pix_valid),
        .i_pix_ready    (pix_ready),
        .i_pix_data     (pix_data),
        .i_pix_last     (pix_last),
        .i_stats_valid  (stats_valid),
        .i_stats_ready  (stats_ready),
        .i_stats_data   (stats_data),
        .i_stats_user   (stats_user),
        .o_fail_count   (fail_count),
        .o_pending      (pending)
    );

    always begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // Result side: a requested hold keeps tready low for a long stretch.
    always @(posedge clk) begin
        if (hold_asks != hold_taken) begin
            hold_taken  <= hold_asks;
            hold_left   <= HOLD_CYCLES;
            stats_ready <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left   <= hold_left - 1;
            stats_ready <= 1'b0;
        end else begin
            stats_ready <= ($urandom_range(99, 0) >= recv_stall_pct);
        end
    end

    initial begin
        while (cycle_count < LIMIT_CYCLES) begin
            @(posedge clk);
            cycle_count++;
        end
        $display("Regression FAIL");
        $finish;
    end

    task automatic push_pixel(input t_level pix, input logic last);
        while (send_idle_pct != 0 && $urandom_range(99, 0) < send_idle_pct) begin
            pix_valid <= 1'b0;
            @(posedge clk);
        end
        pix_valid <= 1'b1;
        pix_data  <= pix;
        pix_last  <= last;
        do @(posedge clk); while (!pix_ready);
    endtask

    // Stop sending and hold until every predicted result is back.
    task automatic drain_results();
        pix_valid <= 1'b0;
        do @(posedge clk); while (pending != 0);
        repeat (8) @(posedge clk);
    endtask

    task automatic write_spread(input t_sigma value);
        cfg_we   <= 1'b1;
        cfg_data <= value;
        @(posedge clk);
        cfg_we   <= 1'b0;
    endtask

    function automatic t_level pick_level(input t_pixel_shape shape, input t_level center);
        int v;
        case (shape)
            SHAPE_FLAT:    return t_level'($urandom_range(255, 0));
            SHAPE_CLUSTER: begin
                v = int'(center) + int'($urandom_range(12, 0)) - 6;
                if (v < 0) v = 0;
                if (v > 255) v = 255;
                return t_level'(v);
            end
            SHAPE_BRIGHT:  return t_level'($urandom_range(255, 224));
            SHAPE_EXTREME: return $urandom_range(1, 0) ? 8'hFF : 8'h00;
            default:       return center;
        endcase
    endfunction

    task automatic send_frame(input int len);
        t_pixel_shape shape;
        t_level       center;
        shape  = t_pixel_shape'($urandom_range(4, 0));
        center = t_level'($urandom_range(255, 0));
        for (int i = 0; i < len; i++) push_pixel(pick_level(shape, center), i == len - 1);
    endtask

    task automatic run_phase(input t_sigma spread, input int unsigned send_pct,
                             input int unsigned recv_pct);
        int sent;
        int len;
        write_spread(spread);
        send_idle_pct  = send_pct;
        recv_stall_pct <= recv_pct;
        sent = 0;
        while (sent < PHASE_ITEMS) begin
            len = ($urandom_range(9, 0) == 0) ? $urandom_range(120, 40) : $urandom_range(24, 1);
            send_frame(len);
            sent += len;
        end
        drain_results();
    endtask

    initial begin
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // reset spread: top level, bottom level, bin 255 as the median, then a median of 200
        push_pixel(8'd255, 1'b1);
        push_pixel(8'd0, 1'b1);
        push_pixel(8'd0, 1'b0);
        push_pixel(8'd255, 1'b1);
        push_pixel(8'd7, 1'b0);
        push_pixel(8'd200, 1'b0);
        push_pixel(8'd200, 1'b0);
        push_pixel(8'd3, 1'b1);
        drain_results();

        // zero spread: both thresholds equal the median
        write_spread('0);
        push_pixel(8'd100, 1'b1);
        push_pixel(8'd37, 1'b0);
        push_pixel(8'd37, 1'b1);
        drain_results();

        // full spread: lower goes to zero, upper clamps or doubles
        write_spread(t_sigma'(Q8_ONE));
        push_pixel(8'd200, 1'b1);
        push_pixel(8'd60, 1'b1);
        drain_results();

        // largest spread the 9-bit register holds
        write_spread(SPREAD_MAX);
        push_pixel(8'd90, 1'b0);
        push_pixel(8'd91, 1'b1);
        push_pixel(8'd255, 1'b1);
        drain_results();

        run_phase(t_sigma'(SIGMA_RESET), 0, 0);

        // hold the result side so the second frame end stalls the pixel input
        recv_stall_pct <= 0;
        hold_asks      <= hold_asks + 1;
        for (int f = 0; f < 3; f++) send_frame($urandom_range(16, 8));
        drain_results();

        run_phase(t_sigma'(Q8_ONE), 45, 0);
        run_phase(t_sigma'($urandom_range(255, 1)), 0, 45);
        run_phase(SPREAD_MAX, 18, 18);
        run_phase('0, 18, 18);

        pix_valid <= 1'b0;
        do @(posedge clk); while (pending != 0);
        repeat (300) @(posedge clk);
        if (fail_count == 0 && pending == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

@@ histogram_median_edge_thresholds.f @@
+incdir+rtl
rtl/hmet_pkg.sv
rtl/hmet_thresh.sv
rtl/histogram_median_edge_thresholds.sv
rtl/hmet_checker.sv
tb/hmet_frame_stats_checker.sv
tb/histogram_median_edge_thresholds_test.sv
